@@ hdl/tab_pkg.sv @@
// Shared types, register indexes and arithmetic helpers of the tinted alpha blitter.
package tab_pkg;

   localparam int MaxDim        = 4096;
   localparam int CsrIndexWidth = 3;
   localparam int DimWidth      = 13;
   localparam int PosWidth      = 14;
   localparam int AddrWidth     = 24;

   localparam logic [CsrIndexWidth-1:0] CsrDstWidth  = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CsrDstHeight = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CsrSrcWidth  = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CsrSrcHeight = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CsrPosX      = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CsrPosY      = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CsrTint      = 3'd6;

   typedef struct packed {
      logic capture;
      logic tint;
      logic blend;
   } tab_cmd_type;

   typedef struct packed {
      logic region_empty;
   } tab_sts_type;

   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] sum;
      sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      return sum[15:8];
   endfunction

   function automatic logic [DimWidth-1:0] sat_dim(input logic [DimWidth-1:0] v);
      return (v > DimWidth'(MaxDim)) ? DimWidth'(MaxDim) : v;
   endfunction

   function automatic logic [DimWidth-1:0] clamp_pos(input logic [PosWidth-1:0] p);
      return p[PosWidth-1] ? '0 : p[DimWidth-1:0];
   endfunction

   function automatic logic [DimWidth-1:0] clip_extent(input logic [DimWidth-1:0] p,
                                                        input logic [DimWidth-1:0] d,
                                                        input logic [DimWidth-1:0] s);
      logic [DimWidth-1:0] rest;
      rest = d - p;
      if (p >= d) begin
         return '0;
      end
      return (rest < s) ? rest : s;
   endfunction

endpackage

@@ hdl/tinted_alpha_blit.sv @@
// Top level of the tinted alpha blitter: controller and datapath.
// Each word passes a capture step, a tint step and a blend step, in that order; the blend step
// waits while an earlier result is not yet taken, and a new word is accepted only after blend.
// A word accepted while the clipped region is empty gives no result.
// Reset: synchronous, active high; state and configuration registers return to their reset values, counters to zero.
module tinted_alpha_blit import tab_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]              csr_data,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [31:0]              req_src_pixel,
   input  logic [31:0]              req_dst_pixel,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [AddrWidth-1:0]     rsp_dst_address,
   output logic [31:0]              rsp_out_pixel,
   output logic                     rsp_last
);

   tab_cmd_type cmd;
   tab_sts_type sts;

   tab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   tab_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_src_pixel   (req_src_pixel),
      .req_dst_pixel   (req_dst_pixel),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_dst_address (rsp_dst_address),
      .rsp_out_pixel   (rsp_out_pixel),
      .rsp_last        (rsp_last)
   );

endmodule

@@ hdl/tab_ctrl.sv @@
// Controller of the tinted alpha blitter: sequences capture, tint and blend steps.
module tab_ctrl import tab_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  tab_sts_type sts,
   output tab_cmd_type cmd
);

   typedef enum logic [1:0] {StIdle, StTint, StBlend} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (!sts.region_empty) begin
                  state_in = StTint;
               end
            end
         end
         StTint: begin
            cmd.tint = 1'b1;
            state_in = StBlend;
         end
         StBlend: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.blend    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/tab_datapath.sv @@
// Datapath of the tinted alpha blitter: registers, clipping, counters, tint, blend, address.
module tab_datapath import tab_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [31:0]              csr_data,
   input  logic [31:0]              req_src_pixel,
   input  logic [31:0]              req_dst_pixel,
   input  tab_cmd_type              cmd,
   output tab_sts_type              sts,
   output logic [AddrWidth-1:0]     rsp_dst_address,
   output logic [31:0]              rsp_out_pixel,
   output logic                     rsp_last
);

   logic [DimWidth-1:0]  dst_width_ff, dst_height_ff, src_width_ff, src_height_ff;
   logic [PosWidth-1:0]  pos_x_ff, pos_y_ff;
   logic [31:0]          tint_ff;
   logic [DimWidth-1:0]  col_ff, row_ff, col_in, row_in;
   logic [DimWidth-1:0]  dw_sat, x0, y0, ext_w, ext_h, col_eff, row_eff;
   logic                 wrap, last_in;
   logic [31:0]          src_ff, dst_ff;
   logic [DimWidth-1:0]  xcoord_ff, ycoord_ff;
   logic                 last_ff;
   logic [7:0]           tc_ff [4];
   logic [7:0]           tc_in [4];
   logic [AddrWidth-1:0] addr_mul_ff, addr_mul_in;
   logic [7:0]           blend_in [3];
   logic [AddrWidth-1:0] rsp_dst_address_ff;
   logic [31:0]          rsp_out_pixel_ff;
   logic                 rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dst_width_ff  <= DimWidth'(1);
         dst_height_ff <= DimWidth'(1);
         src_width_ff  <= DimWidth'(1);
         src_height_ff <= DimWidth'(1);
         pos_x_ff      <= '0;
         pos_y_ff      <= '0;
         tint_ff       <= '1;
      end else if (csr_write) begin
         case (csr_index)
            CsrDstWidth:  dst_width_ff  <= csr_data[DimWidth-1:0];
            CsrDstHeight: dst_height_ff <= csr_data[DimWidth-1:0];
            CsrSrcWidth:  src_width_ff  <= csr_data[DimWidth-1:0];
            CsrSrcHeight: src_height_ff <= csr_data[DimWidth-1:0];
            CsrPosX:      pos_x_ff      <= csr_data[PosWidth-1:0];
            CsrPosY:      pos_y_ff      <= csr_data[PosWidth-1:0];
            CsrTint:      tint_ff       <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      dw_sat  = sat_dim(dst_width_ff);
      x0      = clamp_pos(pos_x_ff);
      y0      = clamp_pos(pos_y_ff);
      ext_w   = clip_extent(x0, dw_sat, sat_dim(src_width_ff));
      ext_h   = clip_extent(y0, sat_dim(dst_height_ff), sat_dim(src_height_ff));
      sts.region_empty = (ext_w == '0) || (ext_h == '0);
      wrap    = (col_ff >= ext_w) || (row_ff >= ext_h);
      col_eff = wrap ? '0 : col_ff;
      row_eff = wrap ? '0 : row_ff;
      last_in = (col_eff + 1'b1 == ext_w) && (row_eff + 1'b1 == ext_h);
      if (col_eff + 1'b1 >= ext_w) begin
         col_in = '0;
         row_in = (row_eff + 1'b1 >= ext_h) ? '0 : row_eff + 1'b1;
      end else begin
         col_in = col_eff + 1'b1;
         row_in = row_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (csr_write && csr_index <= CsrTint) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.capture && !sts.region_empty) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // capture the word and its position in the region
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         src_ff    <= req_src_pixel;
         dst_ff    <= req_dst_pixel;
         xcoord_ff <= x0 + col_eff;
         ycoord_ff <= y0 + row_eff;
         last_ff   <= last_in;
      end
   end

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         tc_in[c] = div255(16'(src_ff[8*c +: 8] * tint_ff[8*c +: 8]));
      end
      addr_mul_in = AddrWidth'(ycoord_ff * dw_sat);
   end

   always_ff @(posedge clock) begin
      if (cmd.tint) begin
         tc_ff       <= tc_in;
         addr_mul_ff <= addr_mul_in;
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         blend_in[c] = div255(16'(tc_ff[c] * tc_ff[3])
                              + 16'(dst_ff[8*c +: 8] * (8'hFF - tc_ff[3])));
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.blend) begin
         rsp_out_pixel_ff   <= {dst_ff[31:24], blend_in[2], blend_in[1], blend_in[0]};
         rsp_dst_address_ff <= addr_mul_ff + AddrWidth'(xcoord_ff);
         rsp_last_ff        <= last_ff;
      end
   end

   assign rsp_dst_address = rsp_dst_address_ff;
   assign rsp_out_pixel   = rsp_out_pixel_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
